@@ hw/rtl/lpr_pkg.sv @@
// Package for the length-prefixed row parser: payload structs, result and
// status codes, parser phases and configuration register indexes.
// No dependencies; every other file of the block uses it.
package lpr_pkg;

    // Largest permitted length-of-length header value.
    localparam int MAX_LEN_BYTES = 8;
    localparam int LEN_LEFT_W    = $clog2(MAX_LEN_BYTES + 1);

    localparam logic [11:0] FIELD_MAX = 12'hFFF;

    // Configuration register indexes.
    localparam logic [7:0] CFG_EMPTY_MARKER = 8'd0;
    localparam logic [7:0] CFG_MAX_LENGTH   = 8'd1;

    typedef enum logic [1:0] {
        KIND_VALUE = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TOO_LONG    = 2'd1,
        ST_TRUNCATED   = 2'd2,
        ST_BAD_LEN_LEN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       row_last;
    } lpr_in_t;

    typedef struct packed {
        kind_t       kind;
        logic [11:0] field_index;
        logic [7:0]  value_byte;
        logic        field_end;
        logic        row_end;
        status_t     status;
    } lpr_out_t;

    // Result of one parse step, handed from the parser to the output stage.
    typedef struct packed {
        logic     valid;
        lpr_out_t data;
    } lpr_res_t;

endpackage

@@ hw/rtl/lpr_parse.sv @@
// Parser state machine of the length-prefixed row parser: holds the row
// state and turns one accepted byte into at most one result.
// Depends on lpr_pkg.
module lpr_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  lpr_pkg::lpr_in_t in_item,
    input  logic [7:0]      empty_marker,
    input  logic [31:0]     max_length,
    output lpr_pkg::lpr_res_t res
);

    lpr_pkg::phase_t                 phase_reg,        phase_next;
    logic [lpr_pkg::LEN_LEFT_W-1:0]  len_left_reg,     len_left_next;
    logic [2:0]                      len_shift_reg,    len_shift_next;
    logic [31:0]                     acc_lo_reg,       acc_lo_next;
    logic                            acc_hi_nz_reg,    acc_hi_nz_next;
    logic [31:0]                     payload_left_reg, payload_left_next;
    logic [11:0]                     field_count_reg,  field_count_next;
    logic                            discarding_reg,   discarding_next;

    logic [7:0]                      b;
    logic                            last;
    logic [11:0]                     field_inc;
    logic [31:0]                     acc_lo_merge;
    logic                            acc_hi_nz_merge;
    logic [lpr_pkg::LEN_LEFT_W-1:0]  len_left_dec;
    logic                            payload_fend;

    always_comb
    begin
        b    = in_item.data_byte;
        last = in_item.row_last;

        field_inc = (field_count_reg == lpr_pkg::FIELD_MAX) ? field_count_reg
                                                             : field_count_reg + 12'd1;

        // Length bytes are little endian; only the low four lanes are kept,
        // the upper lanes only matter for being nonzero.
        if (!len_shift_reg[2])
        begin
            acc_lo_merge    = acc_lo_reg | (32'(b) << {len_shift_reg[1:0], 3'b000});
            acc_hi_nz_merge = acc_hi_nz_reg;
        end
        else
        begin
            acc_lo_merge    = acc_lo_reg;
            acc_hi_nz_merge = acc_hi_nz_reg | (b != 8'd0);
        end

        len_left_dec = (len_left_reg != '0) ? len_left_reg - 1'b1 : len_left_reg;
        payload_fend = (payload_left_reg <= 32'd1);

        phase_next        = phase_reg;
        len_left_next     = len_left_reg;
        len_shift_next    = len_shift_reg;
        acc_lo_next       = acc_lo_reg;
        acc_hi_nz_next    = acc_hi_nz_reg;
        payload_left_next = payload_left_reg;
        field_count_next  = field_count_reg;
        discarding_next   = discarding_reg;

        res                  = '0;
        res.data.kind        = lpr_pkg::KIND_VALUE;
        res.data.status      = lpr_pkg::ST_OK;
        res.data.field_index = field_count_reg;
        res.data.row_end     = last;

        if (step && !discarding_reg)
        begin
            unique case (phase_reg)
                lpr_pkg::PH_HEADER:
                begin
                    if (b == empty_marker || b == 8'd0)
                    begin
                        res.valid          = 1'b1;
                        res.data.kind      = lpr_pkg::KIND_EMPTY;
                        res.data.field_end = 1'b1;
                        field_count_next   = field_inc;
                    end
                    else if (b > 8'(lpr_pkg::MAX_LEN_BYTES))
                    begin
                        res.valid       = 1'b1;
                        res.data.kind   = lpr_pkg::KIND_ERROR;
                        res.data.status = lpr_pkg::ST_BAD_LEN_LEN;
                        discarding_next = 1'b1;
                    end
                    else
                    begin
                        phase_next     = lpr_pkg::PH_LENGTH;
                        len_left_next  = b[lpr_pkg::LEN_LEFT_W-1:0];
                        len_shift_next = 3'd0;
                        acc_lo_next    = 32'd0;
                        acc_hi_nz_next = 1'b0;
                    end
                end
                lpr_pkg::PH_LENGTH:
                begin
                    acc_lo_next    = acc_lo_merge;
                    acc_hi_nz_next = acc_hi_nz_merge;
                    len_shift_next = len_shift_reg + 3'd1;
                    len_left_next  = len_left_dec;
                    if (len_left_dec == '0)
                    begin
                        if (acc_hi_nz_merge || acc_lo_merge > max_length)
                        begin
                            res.valid       = 1'b1;
                            res.data.kind   = lpr_pkg::KIND_ERROR;
                            res.data.status = lpr_pkg::ST_TOO_LONG;
                            discarding_next = 1'b1;
                        end
                        else if (acc_lo_merge == 32'd0)
                        begin
                            res.valid          = 1'b1;
                            res.data.kind      = lpr_pkg::KIND_EMPTY;
                            res.data.field_end = 1'b1;
                            field_count_next   = field_inc;
                            phase_next         = lpr_pkg::PH_HEADER;
                        end
                        else
                        begin
                            payload_left_next = acc_lo_merge;
                            phase_next        = lpr_pkg::PH_PAYLOAD;
                        end
                    end
                end
                lpr_pkg::PH_PAYLOAD:
                begin
                    if (last && !payload_fend)
                    begin
                        res.valid        = 1'b1;
                        res.data.kind    = lpr_pkg::KIND_ERROR;
                        res.data.status  = lpr_pkg::ST_TRUNCATED;
                        discarding_next  = 1'b1;
                    end
                    else
                    begin
                        res.valid           = 1'b1;
                        res.data.value_byte = b;
                        res.data.field_end  = payload_fend;
                        payload_left_next   = (payload_left_reg != 32'd0)
                                              ? payload_left_reg - 32'd1 : payload_left_reg;
                        if (payload_left_next == 32'd0)
                        begin
                            field_count_next = field_inc;
                            phase_next       = lpr_pkg::PH_HEADER;
                        end
                    end
                end
                default:
                begin
                    phase_next = lpr_pkg::PH_HEADER;
                end
            endcase

            // A row that ends inside a field is reported as truncated, unless
            // this byte already raised an error of its own.
            if (last && !discarding_next && phase_next != lpr_pkg::PH_HEADER)
            begin
                res                  = '0;
                res.valid            = 1'b1;
                res.data.kind        = lpr_pkg::KIND_ERROR;
                res.data.status      = lpr_pkg::ST_TRUNCATED;
                res.data.field_index = field_count_reg;
                res.data.row_end     = 1'b1;
            end
        end

        // Every row boundary returns the parser to its reset state.
        if (step && last)
        begin
            phase_next        = lpr_pkg::PH_HEADER;
            len_left_next     = '0;
            len_shift_next    = 3'd0;
            acc_lo_next       = 32'd0;
            acc_hi_nz_next    = 1'b0;
            payload_left_next = 32'd0;
            field_count_next  = 12'd0;
            discarding_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= lpr_pkg::PH_HEADER;
            len_left_reg     <= '0;
            len_shift_reg    <= 3'd0;
            acc_lo_reg       <= 32'd0;
            acc_hi_nz_reg    <= 1'b0;
            payload_left_reg <= 32'd0;
            field_count_reg  <= 12'd0;
            discarding_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            len_left_reg     <= len_left_next;
            len_shift_reg    <= len_shift_next;
            acc_lo_reg       <= acc_lo_next;
            acc_hi_nz_reg    <= acc_hi_nz_next;
            payload_left_reg <= payload_left_next;
            field_count_reg  <= field_count_next;
            discarding_reg   <= discarding_next;
        end
    end

    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_item.row_last |=>
            phase_reg == lpr_pkg::PH_HEADER && field_count_reg == 12'd0 && !discarding_reg)
        else $error("parser state not cleared after row end");

    a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        discarding_reg |-> !res.valid)
        else $error("result produced while discarding a row");

    a_error_discards: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && res.data.kind == lpr_pkg::KIND_ERROR && !in_item.row_last
            |=> discarding_reg)
        else $error("error report did not start discarding");

    a_field_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        step && !in_item.row_last |=> field_count_reg >= $past(field_count_reg))
        else $error("field index went backwards inside a row");

endmodule

@@ hw/rtl/length_prefixed_row_parser.sv @@
// Length-prefixed row parser, top level: configuration registers, the
// parser core and a two-entry output register with skid entry.
// Depends on lpr_pkg and lpr_parse.
//
// Usage: row bytes enter on the in channel (in_valid, in_stall, in_data),
// one byte per transaction, with row_last set on the row's final byte.
// Results leave on the out channel (out_valid, out_stall, out_data), at
// most one per input byte: value bytes, empty-field markers and error
// reports. Other header and length bytes, and bytes of a discarded row, give none.
// A result computed from a taken byte is registered in the output register,
// or in the skid entry when the output register is stalled. Throughput is
// one byte per cycle while in_stall is low.
// When the receiver stalls, one further result is caught in the skid
// entry and in_stall rises the cycle after, so no result is lost.
// The configuration port (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 is empty_marker, index 1 is max_length, other
// indexes are ignored. Write it only while the block is idle.
// Reset clears the parser to the start of a row, empties the output side
// and sets empty_marker to 0 and max_length to all ones.
module length_prefixed_row_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lpr_pkg::lpr_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output lpr_pkg::lpr_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    logic [7:0]        empty_marker_reg;
    logic [31:0]       max_length_reg;

    logic              out_valid_reg;
    lpr_pkg::lpr_out_t out_data_reg;
    logic              skid_valid_reg;
    lpr_pkg::lpr_out_t skid_data_reg;

    logic              in_take;
    logic              out_take;
    lpr_pkg::lpr_res_t res;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_take   = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_marker_reg <= 8'd0;
            max_length_reg   <= 32'hFFFF_FFFF;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lpr_pkg::CFG_EMPTY_MARKER: empty_marker_reg <= cfg_data[7:0];
                lpr_pkg::CFG_MAX_LENGTH:   max_length_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    lpr_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_take),
        .in_item      (in_data),
        .empty_marker (empty_marker_reg),
        .max_length   (max_length_reg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take && res.valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_take && res.valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= res.data;
            end
            else
            begin
                out_data_reg <= res.data;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_take |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry did not move to the output register");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed before it was taken");

endmodule
